>>> design/cst_pkg.sv
// cst_pkg: shared types, constants and character-class helpers for the
// character stream tokenizer; no dependencies
package cst_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_TOKEN_LEN = 31;
    localparam int DEF_OFFSET_WIDTH  = 16;

    // fixed field widths of the item payloads
    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 3;
    localparam int START_W = 16;
    localparam int LENF_W  = 5;

    // character codes
    localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ     = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ     = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;

    // automaton states
    typedef enum logic [3:0] {
        LEX_IDLE  = 4'd0,
        LEX_ID    = 4'd1,
        LEX_INT   = 4'd2,
        LEX_FLOAT = 4'd3,
        LEX_OP    = 4'd4,
        LEX_SEP   = 4'd5
    } t_lex_state;

    // token kinds as reported
    typedef enum logic [KIND_W-1:0] {
        KIND_IDENT = 3'd0,
        KIND_INT   = 3'd1,
        KIND_FLOAT = 3'd2,
        KIND_OP    = 3'd3,
        KIND_SEP   = 3'd4
    } t_token_kind;

    // input item
    typedef struct packed {
        logic [CHAR_W-1:0] in_char;
        logic              end_of_input;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [KIND_W-1:0]  token_kind;
        logic [CHAR_W-1:0]  first_char;
        logic [START_W-1:0] token_start;
        logic [LENF_W-1:0]  token_length;
        logic               truncated;
    } t_out_item;

    // character classes
    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c inside {[CH_0:CH_9]};
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return c inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]};
    endfunction

    function automatic logic is_oper(input logic [CHAR_W-1:0] c);
        return c inside {CH_PLUS, CH_MINUS, CH_EQUAL};
    endfunction

    function automatic logic is_sepr(input logic [CHAR_W-1:0] c);
        return c inside {CH_LPAREN, CH_RPAREN};
    endfunction

    // kind of the token held in a given state
    function automatic t_token_kind kind_of(input t_lex_state s);
        t_token_kind k;
        case (s)
            LEX_ID:    k = KIND_IDENT;
            LEX_INT:   k = KIND_INT;
            LEX_FLOAT: k = KIND_FLOAT;
            LEX_OP:    k = KIND_OP;
            LEX_SEP:   k = KIND_SEP;
            default:   k = KIND_IDENT;
        endcase
        return k;
    endfunction

endpackage

>>> design/cst_stream_if.sv
// cst_stream_if: valid/ready channel carrying one payload item
// payload type is a parameter, normally a struct from cst_pkg
interface cst_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/char_stream_tokenizer.sv
// char_stream_tokenizer: top level, tokenizer automaton over a character stream
// depends on cst_pkg and cst_stream_if
//
// channel  dir  payload     handshake
// i_in     in   t_in_item   valid/ready, accepted when both high
// o_out    out  t_out_item  valid/ready, accepted when both high
//
// one character per cycle unless the output stalls: input register, one step of the automaton,
// result register; an accepted character is held in the input register, and the automaton step
// then loads the state registers and, for an emitted token, the result register together
// a character that ends a token emits that token; single-character operators
// and separators are held until the next character or end of input
// synchronous active-low reset returns the automaton to idle at offset 0
// a stalled result register holds the step stage and, through ready, the input
module char_stream_tokenizer
    import cst_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN,
    parameter int OFFSET_WIDTH  = DEF_OFFSET_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cst_stream_if.sink   i_in,
    cst_stream_if.source o_out
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    // input register
    logic     r_in_valid;
    t_in_item r_in_data;

    // automaton state
    t_lex_state              r_lex, n_lex;
    logic [LEN_W-1:0]        r_len, n_len;
    logic [OFFSET_WIDTH-1:0] r_start, n_start;
    logic [CHAR_W-1:0]       r_first, n_first;
    logic [OFFSET_WIDTH-1:0] r_offset, n_offset;
    logic                    r_ovf, n_ovf;

    // result register
    logic      r_out_valid;
    t_out_item r_out_data;

    logic      advance;
    logic      emit;
    t_out_item pend_item;
    logic [LEN_W+LENF_W-1:0]          len_ext;
    logic [OFFSET_WIDTH+START_W-1:0]  start_ext;
    logic [CHAR_W-1:0]                c;
    logic [LEN_W-1:0]                 len_inc;
    logic                             ovf_inc;

    // handshake: step the automaton when the result register can take a result
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_data <= i_in.data;
        end
    end

    // pending token as a result item, widths fitted to the fields
    assign len_ext   = {{LENF_W{1'b0}}, r_len};
    assign start_ext = {{START_W{1'b0}}, r_start};
    always_comb begin
        pend_item.token_kind   = kind_of(r_lex);
        pend_item.first_char   = r_first;
        pend_item.token_start  = start_ext[START_W-1:0];
        pend_item.token_length = len_ext[LENF_W-1:0];
        pend_item.truncated    = r_ovf;
    end

    // saturating append
    assign len_inc = (r_len >= LEN_MAX) ? LEN_MAX : r_len + LEN_ONE;
    assign ovf_inc = (r_len >= LEN_MAX) ? 1'b1 : r_ovf;

    // one automaton step
    assign c = r_in_data.in_char;
    always_comb begin
        n_lex    = r_lex;
        n_len    = r_len;
        n_start  = r_start;
        n_first  = r_first;
        n_offset = r_offset;
        n_ovf    = r_ovf;
        emit     = 1'b0;
        if (r_in_data.end_of_input) begin
            emit  = (r_lex != LEX_IDLE);
            n_lex = LEX_IDLE;
            n_len = '0;
            n_ovf = 1'b0;
        end else begin
            n_offset = r_offset + OFFSET_WIDTH'(1);
            if ((r_lex == LEX_ID && (is_letter(c) || is_digit(c))) ||
                ((r_lex == LEX_INT || r_lex == LEX_FLOAT) && is_digit(c))) begin
                n_len = len_inc;
                n_ovf = ovf_inc;
            end else if (r_lex == LEX_INT && c == CH_DOT) begin
                n_lex = LEX_FLOAT;
                n_len = len_inc;
                n_ovf = ovf_inc;
            end else begin
                emit = (r_lex != LEX_IDLE);
                if (is_digit(c)) begin
                    n_lex = LEX_INT;
                end else if (is_letter(c)) begin
                    n_lex = LEX_ID;
                end else if (is_oper(c)) begin
                    n_lex = LEX_OP;
                end else if (is_sepr(c)) begin
                    n_lex = LEX_SEP;
                end else begin
                    n_lex = LEX_IDLE;
                end
                n_ovf = 1'b0;
                if (n_lex != LEX_IDLE) begin
                    n_start = r_offset;
                    n_first = c;
                    n_len   = LEN_ONE;
                end else begin
                    n_len = '0;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lex    <= LEX_IDLE;
            r_len    <= '0;
            r_start  <= '0;
            r_first  <= '0;
            r_offset <= '0;
            r_ovf    <= 1'b0;
        end else if (advance) begin
            r_lex    <= n_lex;
            r_len    <= n_len;
            r_start  <= n_start;
            r_first  <= n_first;
            r_offset <= n_offset;
            r_ovf    <= n_ovf;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && emit) begin
            r_out_data <= pend_item;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // checks
    a_eoi_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_data.end_of_input |=> r_lex == LEX_IDLE && r_len == '0)
        else $error("end of input did not return to idle");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lex == LEX_IDLE |-> r_len == '0 && !r_ovf)
        else $error("idle state with a pending length");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_len == LEN_MAX)
        else $error("overflow flag without saturated length");

    a_pending_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lex != LEX_IDLE |-> r_len != '0)
        else $error("pending token with zero length");

endmodule
